[rtl/core/i2cbe_pkg.sv]
`default_nettype none

package i2cbe_pkg;

    // Width of the delay counter and of the ticks-per-delay register.
    localparam int DELAY_W = 16;

    // Reset value of the ticks-per-delay register.
    localparam logic [DELAY_W-1:0] TICKS_RESET = 16'd100;

    // Register index decoded from the APB word address.
    localparam logic REG_TICKS = 1'b0;

    // Bus commands carried in the slave-side tuser.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // One classified tick as it travels from the front end to the sequencer.
    typedef struct packed {
        logic       cmd_valid;
        t_cmd       cmd;
        logic [7:0] tx;
        logic       sda;
    } t_item;

    // One result beat as the sequencer reports it.
    typedef struct packed {
        logic       ack;
        logic [7:0] rx;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/i2cbe_front.sv]
`default_nettype none

module i2cbe_front
    import i2cbe_pkg::*;
(
    input  wire        i_valid,
    input  wire        i_cmd_valid,
    input  wire  [1:0] i_command,
    input  wire  [7:0] i_tx_byte,
    input  wire        i_sda_level,
    input  wire        i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    t_cmd cmd;

    // A beat is taken whenever the queue has a free slot.
    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Decode the command and keep the transmit byte only for a write, so the
    // sequencer can load its shift register straight from the item.
    always_comb begin
        cmd              = t_cmd'(i_command);
        o_item.cmd_valid = i_cmd_valid;
        o_item.cmd       = cmd;
        o_item.sda       = i_sda_level;
        o_item.tx        = (i_cmd_valid && (cmd == CMD_WRITE)) ? i_tx_byte : 8'h00;
    end

endmodule

`default_nettype wire

[rtl/core/i2cbe_queue.sv]
`default_nettype none

module i2cbe_queue
    import i2cbe_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_item      i_item,
    input  wire        i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    t_item            r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic [QAW:0]     n_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    // Occupancy follows pushes and pops; both may happen in the same cycle.
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2cbe_back.sv]
`default_nettype none

module i2cbe_back
    import i2cbe_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [DELAY_W-1:0] i_ticks,
    input  wire                i_q_valid,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  wire                i_ready,
    output t_result            o_result
);

    logic [4:0]         r_phase;
    logic [4:0]         n_phase;
    logic [1:0]         r_sub;
    logic [1:0]         n_sub;
    logic [DELAY_W-1:0] r_tick;
    logic [DELAY_W-1:0] n_tick;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [7:0]         r_shift;
    logic [7:0]         n_shift;
    logic               r_busy;
    logic               n_busy;
    logic               r_ack;
    logic               n_ack;
    logic               r_scl;
    logic               n_scl;
    logic               r_sda;
    logic               n_sda;
    logic [7:0]         r_rx;
    logic [7:0]         n_rx;
    logic               n_done;
    logic               r_ov;
    t_result            r_res;
    logic               adv;
    logic [DELAY_W-1:0] eff_delay;

    // Number of delay phases in each command sequence.
    function automatic logic [4:0] phase_total(input t_cmd c);
        logic [4:0] t;
        unique case (c)
            CMD_START: t = 5'd4;
            CMD_STOP:  t = 5'd4;
            CMD_WRITE: t = 5'd28;
            CMD_READ:  t = 5'd21;
            default:   t = 5'd21;
        endcase
        return t;
    endfunction

    // A zero delay register counts as one tick.
    assign eff_delay = (i_ticks == '0) ? DELAY_W'(1) : i_ticks;

    // One tick is consumed when the output register is free or being emptied.
    assign adv      = i_q_valid && (!r_ov || i_ready);
    assign o_pop    = adv;
    assign o_valid  = r_ov;
    assign o_result = r_res;

    // Sequencer step for the tick at the head of the queue.
    always_comb begin
        logic       a_en;
        t_cmd       a_cmd;
        logic [4:0] a_ph;
        logic [1:0] a_sub;
        logic [4:0] ph_next;

        n_phase = r_phase;
        n_sub   = r_sub;
        n_tick  = r_tick;
        n_cmd   = r_cmd;
        n_shift = r_shift;
        n_busy  = r_busy;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_rx    = r_rx;
        n_done  = 1'b0;
        a_en    = 1'b0;
        a_cmd   = r_cmd;
        a_ph    = 5'd0;
        a_sub   = 2'd0;
        ph_next = r_phase + 5'd1;

        if (r_busy) begin
            n_tick = r_tick + 1'b1;
            if (n_tick >= eff_delay) begin
                n_tick = '0;
                n_sub  = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
                if (ph_next >= phase_total(r_cmd)) begin
                    if (r_cmd == CMD_WRITE) begin
                        n_ack = !i_item.sda;
                        n_scl = 1'b0;
                    end else if (r_cmd == CMD_READ) begin
                        n_rx = r_shift;
                    end
                    n_busy  = 1'b0;
                    n_phase = 5'd0;
                    n_done  = 1'b1;
                end else begin
                    n_phase = ph_next;
                    a_en    = 1'b1;
                    a_ph    = ph_next;
                    a_sub   = n_sub;
                end
            end
        end else if (i_item.cmd_valid) begin
            n_cmd   = i_item.cmd;
            n_busy  = 1'b1;
            n_phase = 5'd0;
            n_sub   = 2'd0;
            n_tick  = '0;
            n_shift = i_item.tx;
            a_en    = 1'b1;
            a_cmd   = i_item.cmd;
        end

        // Level change and sample that open the new phase.
        if (a_en) begin
            unique case (a_cmd)
                CMD_START: begin
                    unique case (a_ph[1:0])
                        2'd0:    n_scl = 1'b1;
                        2'd1:    n_sda = 1'b1;
                        2'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                end
                CMD_STOP: begin
                    unique case (a_ph[1:0])
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_sda = 1'b0;
                        2'd2:    n_scl = 1'b1;
                        default: n_sda = 1'b1;
                    endcase
                end
                CMD_WRITE: begin
                    if (a_ph < 5'd24) begin
                        if (a_sub == 2'd0) begin
                            n_scl = 1'b0;
                        end else if (a_sub == 2'd1) begin
                            n_sda   = n_shift[7];
                            n_shift = {n_shift[6:0], 1'b0};
                        end else begin
                            n_scl = 1'b1;
                        end
                    end else if (a_ph == 5'd24 || a_ph == 5'd25) begin
                        n_scl = 1'b0;
                    end else if (a_ph == 5'd26) begin
                        n_sda = 1'b1;
                    end else begin
                        n_scl = 1'b1;
                    end
                end
                default: begin
                    if (a_ph == 5'd0) begin
                        n_scl = 1'b0;
                    end else if (a_ph <= 5'd16) begin
                        if (a_ph[0]) begin
                            if (a_ph == 5'd1) begin
                                n_sda = 1'b1;
                            end
                            n_scl = 1'b1;
                        end else begin
                            n_shift = {n_shift[6:0], i_item.sda};
                            n_scl   = 1'b0;
                        end
                    end else if (a_ph == 5'd18) begin
                        n_sda = 1'b0;
                    end else if (a_ph == 5'd19) begin
                        n_scl = 1'b1;
                    end else begin
                        n_scl = 1'b0;
                    end
                end
            endcase
        end
    end

    // Sequencer state advances only with a consumed tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_sub   <= '0;
            r_tick  <= '0;
            r_cmd   <= CMD_START;
            r_shift <= '0;
            r_busy  <= 1'b0;
            r_ack   <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_rx    <= '0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_tick  <= n_tick;
            r_cmd   <= n_cmd;
            r_shift <= n_shift;
            r_busy  <= n_busy;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_rx    <= n_rx;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res.scl  <= n_scl;
            r_res.sda  <= n_sda;
            r_res.busy <= n_busy;
            r_res.done <= n_done;
            r_res.rx   <= n_rx;
            r_res.ack  <= n_ack;
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2c_master_bit_engine_core.sv]
`default_nettype none

// Channel    Direction  Handshake                Payload
// s_axis     in         tvalid/tready            tdata: tx_byte, sda_level; tuser: cmd_valid, command
// m_axis     out        tvalid/tready            tdata: scl, sda, busy, done, rx_byte, ack
// apb        in         psel/penable/pready      ticks_per_delay at byte address 0
//
// Every input beat is one bus-timer tick and yields exactly one output beat.
// Beats are taken back to back, one per cycle, while the queue has room; each beat
// passes through the front queue and then the output register.
// Reset is synchronous and active low; it empties the queue and output register
// and loads ticks_per_delay with 100.
// When the master side stalls, up to two further beats wait in the queue before
// s_axis_tready drops.

module i2c_master_bit_engine_core
    import i2cbe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [7:0] tx_byte, [8] sda_level, [15:9] zero
    input  wire  [2:0]  s_axis_tuser,   // [0] cmd_valid, [2:1] command
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] scl, [1] sda, [2] busy, [3] done,
                                        // [11:4] rx_byte, [12] ack_received, [15:13] zero
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DELAY_W-1:0] r_ticks;
    logic               cfg_wr;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    t_item              f_item;
    t_item              q_item;
    t_result            res;

    // Configuration register; only word address zero holds a register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= TICKS_RESET;
        end else if (cfg_wr) begin
            r_ticks <= pwdata[DELAY_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TICKS) ? {{(32-DELAY_W){1'b0}}, r_ticks} : 32'h0;

    // Front end: classifies each beat and places it in the queue.
    i2cbe_front u_front (
        .i_valid     (s_axis_tvalid),
        .i_cmd_valid (s_axis_tuser[0]),
        .i_command   (s_axis_tuser[2:1]),
        .i_tx_byte   (s_axis_tdata[7:0]),
        .i_sda_level (s_axis_tdata[8]),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (push),
        .o_item      (f_item)
    );

    i2cbe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back end: pin sequencer and output register.
    i2cbe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ticks   (r_ticks),
        .i_q_valid (q_valid),
        .i_item    (q_item),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_result  (res)
    );

    assign m_axis_tdata = {3'b000, res.ack, res.rx, res.done, res.busy, res.sda, res.scl};

endmodule

`default_nettype wire

[rtl/core/i2cbe_checker.sv]
`default_nettype none

module i2cbe_checker
    import i2cbe_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        psel,
    input wire        penable,
    input wire        pwrite,
    input wire [2:0]  paddr,
    input wire [31:0] pwdata,
    input wire [31:0] prdata,
    input wire        pready
);

    logic cfg_wr0;

    assign cfg_wr0 = psel && penable && pwrite && pready && (paddr[2] == REG_TICKS);

    // A stalled result beat stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // A completing tick never reports the sequencer as still busy.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done and busy reported together");

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat offered after reset");

    // The delay register reads back the value last written.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(cfg_wr0) && (paddr[2] == REG_TICKS) |->
            prdata == {{(32-DELAY_W){1'b0}}, $past(pwdata[DELAY_W-1:0])})
        else $error("delay register readback mismatch");

endmodule

bind i2c_master_bit_engine_core i2cbe_checker u_i2cbe_checker (.*);

`default_nettype wire

[dv/i2cbe_bus_checker.sv]
module i2cbe_bus_checker
    import i2cbe_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [15:0] i_s_tdata,   // [7:0] tx_byte, [8] sda_level, [15:9] zero
    input  wire  [2:0]  i_s_tuser,   // [0] cmd_valid, [2:1] command
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [15:0] i_m_tdata,   // [0] scl, [1] sda, [2] busy, [3] done,
                                     // [11:4] rx_byte, [12] ack_received
    input  wire         i_psel,
    input  wire         i_penable,
    input  wire         i_pwrite,
    input  wire  [2:0]  i_paddr,
    input  wire  [31:0] i_pwdata,
    input  wire         i_pready,
    output int          o_fails,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the sequencer state and of the delay register.
    logic [DELAY_W-1:0] ticks_cfg;
    logic [DELAY_W-1:0] tick_cnt;
    logic [4:0]         phase;
    t_cmd               cur_cmd;
    logic [7:0]         shifter;
    logic               busy;
    logic               ack;
    logic               scl;
    logic               sda;
    logic [7:0]         rx_held;

    // Pin reports still owed by the block, oldest first.
    t_result pin_reports_q[$];

    function automatic logic [4:0] phases_of(t_cmd c);
        case (c)
            CMD_START: return 5'd4;
            CMD_STOP:  return 5'd4;
            CMD_WRITE: return 5'd28;
            default:   return 5'd21;
        endcase
    endfunction

    // Level change and sampling that open phase p of command c.
    function automatic void open_phase(t_cmd c, logic [4:0] p, logic sda_in);
        case (c)
            CMD_START: begin
                case (p)
                    5'd0:    scl = 1'b1;
                    5'd1:    sda = 1'b1;
                    5'd2:    sda = 1'b0;
                    5'd3:    scl = 1'b0;
                    default: ;
                endcase
            end
            CMD_STOP: begin
                case (p)
                    5'd0:    scl = 1'b0;
                    5'd1:    sda = 1'b0;
                    5'd2:    scl = 1'b1;
                    5'd3:    sda = 1'b1;
                    default: ;
                endcase
            end
            CMD_WRITE: begin
                // Eight bit slots of three phases each, then the acknowledge slot.
                if (p < 5'd24) begin
                    if (p % 3 == 0) begin
                        scl = 1'b0;
                    end else if (p % 3 == 1) begin
                        sda     = shifter[7];
                        shifter = {shifter[6:0], 1'b0};
                    end else begin
                        scl = 1'b1;
                    end
                end else if (p == 5'd24 || p == 5'd25) begin
                    scl = 1'b0;
                end else if (p == 5'd26) begin
                    sda = 1'b1;
                end else begin
                    scl = 1'b1;
                end
            end
            default: begin
                // Read: in phases one to sixteen, odd phases raise SCL, even phases sample and drop it.
                if (p == 5'd0) begin
                    scl = 1'b0;
                end else if (p <= 5'd16) begin
                    if (p[0]) begin
                        if (p == 5'd1) begin
                            sda = 1'b1;
                        end
                        scl = 1'b1;
                    end else begin
                        shifter = {shifter[6:0], sda_in};
                        scl     = 1'b0;
                    end
                end else if (p == 5'd17) begin
                    scl = 1'b0;
                end else if (p == 5'd18) begin
                    sda = 1'b0;
                end else if (p == 5'd19) begin
                    scl = 1'b1;
                end else begin
                    scl = 1'b0;
                end
            end
        endcase
    endfunction

    // One bus-timer tick: advance the shadow state and report the pins.
    function automatic t_result advance_bus_tick(t_item it);
        t_result            r;
        logic [DELAY_W-1:0] eff;
        r.done = 1'b0;
        eff    = (ticks_cfg == '0) ? DELAY_W'(1) : ticks_cfg;
        if (busy) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= eff) begin
                tick_cnt = '0;
                phase    = phase + 1'b1;
                if (phase >= phases_of(cur_cmd)) begin
                    if (cur_cmd == CMD_WRITE) begin
                        ack = ~it.sda;
                        scl = 1'b0;
                    end else if (cur_cmd == CMD_READ) begin
                        rx_held = shifter;
                    end
                    busy   = 1'b0;
                    phase  = '0;
                    r.done = 1'b1;
                end else begin
                    open_phase(cur_cmd, phase, it.sda);
                end
            end
        end else if (it.cmd_valid) begin
            cur_cmd  = it.cmd;
            busy     = 1'b1;
            phase    = '0;
            tick_cnt = '0;
            shifter  = (it.cmd == CMD_WRITE) ? it.tx : 8'h00;
            open_phase(it.cmd, 5'd0, it.sda);
        end
        r.scl  = scl;
        r.sda  = sda;
        r.busy = busy;
        r.rx   = rx_held;
        r.ack  = ack;
        return r;
    endfunction

    function automatic int field_diff(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("time %0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Watch the register port and both streams at every edge.
    always @(posedge i_clk) begin
        t_item   item;
        t_result want;
        t_result got;
        int      errs;
        errs = 0;
        if (!i_rst_n) begin
            ticks_cfg = TICKS_RESET;
            tick_cnt  = '0;
            phase     = '0;
            cur_cmd   = CMD_START;
            shifter   = '0;
            busy      = 1'b0;
            ack       = 1'b0;
            scl       = 1'b1;
            sda       = 1'b1;
            rx_held   = '0;
            pin_reports_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_TICKS) begin
                ticks_cfg = i_pwdata[DELAY_W-1:0];
            end

            // Compare a result beat against the oldest expectation.
            if (i_m_tvalid && i_m_tready) begin
                got.scl  = i_m_tdata[0];
                got.sda  = i_m_tdata[1];
                got.busy = i_m_tdata[2];
                got.done = i_m_tdata[3];
                got.rx   = i_m_tdata[11:4];
                got.ack  = i_m_tdata[12];
                if (pin_reports_q.size() == 0) begin
                    $display("time %0t: unexpected result beat, expected none, actual 0x%0h",
                             $time, i_m_tdata);
                    errs = errs + 1;
                end else begin
                    want = pin_reports_q.pop_front();
                    errs = errs + field_diff("scl", want.scl, got.scl);
                    errs = errs + field_diff("sda", want.sda, got.sda);
                    errs = errs + field_diff("busy", want.busy, got.busy);
                    errs = errs + field_diff("done", want.done, got.done);
                    errs = errs + field_diff("rx_byte", want.rx, got.rx);
                    errs = errs + field_diff("ack_received", want.ack, got.ack);
                end
            end

            // Every accepted tick owes exactly one pin report.
            if (i_s_tvalid && i_s_tready) begin
                item.cmd_valid = i_s_tuser[0];
                item.cmd       = t_cmd'(i_s_tuser[2:1]);
                item.tx        = i_s_tdata[7:0];
                item.sda       = i_s_tdata[8];
                pin_reports_q.push_back(advance_bus_tick(item));
            end
        end
        o_fails   <= o_fails + errs;
        o_pending <= pin_reports_q.size();
    end

endmodule

[dv/tb_top.sv]
module tb_top
    import i2cbe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD = 100;

    logic        i_clk;
    logic        i_rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // [7:0] tx_byte, [8] sda_level, [15:9] zero
    logic [2:0]  s_tuser = '0;    // [0] cmd_valid, [2:1] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [0] scl, [1] sda, [2] busy, [3] done,
                                  // [11:4] rx_byte, [12] ack_received
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fails;
    int pending;

    logic src_idling = 1'b0;
    logic sink_idling = 1'b0;
    int   hold_reqs = 0;
    int   hold_done = 0;
    int   sink_wait = 0;

    // Delay currently programmed, used to size directed command windows.
    logic [DELAY_W-1:0] cur_ticks = TICKS_RESET;

    i2c_master_bit_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    i2cbe_bus_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .i_pready   (pready),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stall bursts, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            sink_wait <= 0;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_tready  <= 1'b0;
        end else if (hold_done != hold_reqs) begin
            hold_done <= hold_done + 1;
            sink_wait <= LONG_HOLD - 1;
            m_tready  <= 1'b0;
        end else if (sink_idling && $urandom_range(0, 9) == 0) begin
            sink_wait <= $urandom_range(0, 15);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Offer one tick beat and hold it until the block takes it.
    task automatic send_beat(input logic cv, input t_cmd c, input logic [7:0] tx,
                             input logic sda_lvl);
        int unsigned gap;
        if (src_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, sda_lvl, tx};
        s_tuser  <= {c, cv};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every owed result plus the pipeline latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_TICKS) begin
            cur_ticks = data[DELAY_W-1:0];
        end
    endtask

    task automatic random_ticks(input int n);
        repeat (n) begin
            send_beat($urandom_range(0, 3) == 0, t_cmd'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Ticks with no command, long enough for any sequence to finish.
    task automatic quiet_ticks(input int n);
        repeat (n) begin
            send_beat(1'b0, t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    // Issue a command on an idle engine and run it to completion with a fixed
    // SDA level. A command is offered on every busy tick too, the completing
    // tick included, and must be ignored.
    task automatic run_cmd(input t_cmd c, input logic [7:0] tx, input logic sda_lvl);
        int span;
        int eff;
        eff = (cur_ticks == '0) ? 1 : int'(cur_ticks);
        case (c)
            CMD_WRITE: span = 28 * eff;
            CMD_READ:  span = 21 * eff;
            default:   span = 4 * eff;
        endcase
        send_beat(1'b1, c, tx, sda_lvl);
        repeat (span) begin
            send_beat(1'b1, t_cmd'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      sda_lvl);
        end
    endtask

    initial begin : stimulus
        int unsigned delays[5];
        delays = '{2, 1, 3, 0, 5};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        src_idling  <= 1'b1;
        sink_idling <= 1'b1;

        // A start at the reset delay, then the directed commands at delay one.
        run_cmd(CMD_START, 8'h00, 1'b1);
        drain();
        apb_write(3'd0, 32'd1);
        run_cmd(CMD_START, 8'h3C, 1'b0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0);
        run_cmd(CMD_WRITE, 8'h00, 1'b1);
        run_cmd(CMD_READ, 8'hFF, 1'b1);
        run_cmd(CMD_READ, 8'h00, 1'b0);
        run_cmd(CMD_STOP, 8'hA5, 1'b1);
        drain();

        // A write outside the register map must leave the delay alone.
        apb_write(3'd4, 32'h0000_0007);
        run_cmd(CMD_WRITE, 8'h5A, 1'b0);
        drain();

        // A zero delay behaves as one tick.
        apb_write(3'd0, 32'd0);
        run_cmd(CMD_START, 8'h00, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0);

        // Random traffic over several delays, with both pressure cases.
        for (int i = 0; i < 5; i++) begin
            drain();
            apb_write(3'd0, delays[i]);
            random_ticks(90);
            if (i == 1) begin
                hold_reqs <= hold_reqs + 1;
            end
            if (i == 2) begin
                drain();
            end
            random_ticks(90);
        end

        // Largest delay: the first phase holds across a long run of ticks.
        drain();
        src_idling  <= 1'b0;
        sink_idling <= 1'b0;
        apb_write(3'd0, 32'd1);
        quiet_ticks(40);
        drain();
        apb_write(3'd0, 32'h0000_FFFF);
        send_beat(1'b1, CMD_START, 8'h00, 1'b0);
        random_ticks(60);

        // Closing stretch at full rate on both sides.
        drain();
        apb_write(3'd0, 32'd1);
        random_ticks(150);
        drain();

        if (fails == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
